// File: rtl/fsu_pkg.sv
package fsu_pkg;

    // Data formats.
    localparam int DATA_W         = 64;
    localparam int REG_W          = 63;
    localparam int FRAC_BITS      = 24;
    localparam int CF_BITS        = 30;
    localparam int CF_W           = 32;
    localparam int HO_W           = 3;
    localparam int MAX_HALF_ORDER = 6;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int DIV_STEPS      = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Stream and configuration port widths.
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 392;
    localparam int OUT_TDATA_W = 264;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [DATA_W-1:0] S64_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S64_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Item kinds carried in tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TAP   = 2'd0,
        OP_PMLX  = 2'd1,
        OP_PMLZ  = 2'd2,
        OP_POINT = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_ORDER = 3'd0,
        REG_COEFF_SET  = 3'd1,
        REG_PML_ENABLE = 3'd2,
        REG_TIME_STEP  = 3'd3,
        REG_INV_DX     = 3'd4,
        REG_INV_DY     = 3'd5,
        REG_INV_DZ     = 3'd6
    } t_cfg_reg;

    // Back part sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_TAP_X, ST_TAP_Y, ST_TAP_Z,
        ST_VXX, ST_VYY, ST_VZZ,
        ST_PX_B, ST_PX_A, ST_PX_DIV,
        ST_PZ_B, ST_PZ_A, ST_PZ_DIV,
        ST_T1, ST_T2, ST_T3, ST_T4, ST_HDIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic [HO_W-1:0]  half_order_eff;
        logic             coeff_set;
        logic             pml_enable;
        logic [REG_W-1:0] time_step;
        logic [REG_W-1:0] inv_dx;
        logic [REG_W-1:0] inv_dy;
        logic [REG_W-1:0] inv_dz;
    } t_cfg;

    typedef struct packed {
        t_op                     kind;
        logic signed [CF_W-1:0]  coef;
        logic                    xr;
        logic                    zr;
        logic signed [DATA_W-1:0] va;
        logic signed [DATA_W-1:0] vb;
        logic signed [DATA_W-1:0] vc;
        logic signed [DATA_W-1:0] vd;
        logic signed [DATA_W-1:0] ve;
        logic signed [DATA_W-1:0] vf;
    } t_entry;

    typedef struct packed {
        logic                     fault;
        logic signed [DATA_W-1:0] psz;
        logic signed [DATA_W-1:0] psx;
        logic signed [DATA_W-1:0] szz;
        logic signed [DATA_W-1:0] sxx;
    } t_result;

    // Stencil coefficients in Q.30, rounded to nearest.
    localparam longint K31 = 64'sd2147483648;
    localparam logic signed [CF_W-1:0] CF_TAB [2][MAX_HALF_ORDER][MAX_HALF_ORDER] = '{
        '{
            '{32'((1*K31+1)/(2*1)), 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'((9*K31+8)/(2*8)), 32'(-((1*K31+24)/(2*24))),
              32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'((75*K31+64)/(2*64)), 32'(-((25*K31+384)/(2*384))),
              32'((3*K31+640)/(2*640)), 32'sd0, 32'sd0, 32'sd0},
            '{32'((1225*K31+1024)/(2*1024)), 32'(-((245*K31+3072)/(2*3072))),
              32'((49*K31+5120)/(2*5120)), 32'(-((5*K31+7168)/(2*7168))),
              32'sd0, 32'sd0},
            '{32'((19845*K31+16384)/(2*16384)), 32'(-((735*K31+8192)/(2*8192))),
              32'((567*K31+40960)/(2*40960)), 32'(-((405*K31+229376)/(2*229376))),
              32'((35*K31+294912)/(2*294912)), 32'sd0},
            '{32'((160083*K31+131072)/(2*131072)),
              32'(-((12705*K31+131072)/(2*131072))),
              32'((22869*K31+1310720)/(2*1310720)),
              32'(-((5445*K31+1835008)/(2*1835008))),
              32'((847*K31+2359296)/(2*2359296)),
              32'(-((63*K31+2883584)/(2*2883584)))}
        },
        '{
            '{32'((1*K31+1)/(2*1)), 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'((11382*K31+10000)/(2*10000)),
              32'(-((46414*K31+1000000)/(2*1000000))),
              32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'((11965*K31+10000)/(2*10000)),
              32'(-((78804*K31+1000000)/(2*1000000))),
              32'((81781*K31+10000000)/(2*10000000)), 32'sd0, 32'sd0, 32'sd0},
            '{32'((12257*K31+10000)/(2*10000)),
              32'(-((99537*K31+1000000)/(2*1000000))),
              32'((18063*K31+1000000)/(2*1000000)),
              32'(-((26274*K31+10000000)/(2*10000000))), 32'sd0, 32'sd0},
            '{32'((12415*K31+10000)/(2*10000)),
              32'(-((11231*K31+100000)/(2*100000))),
              32'((26191*K31+1000000)/(2*1000000)),
              32'(-((64682*K31+10000000)/(2*10000000))),
              32'((1191*K31+1000000)/(2*1000000)), 32'sd0},
            '{32'((12508*K31+10000)/(2*10000)),
              32'(-((12034*K31+100000)/(2*100000))),
              32'((32131*K31+1000000)/(2*1000000)),
              32'(-((10142*K31+1000000)/(2*1000000))),
              32'((29857*K31+10000000)/(2*10000000)),
              32'(-((66667*K31+100000000)/(2*100000000)))}
        }
    };

    // Saturating add.
    function automatic logic signed [DATA_W-1:0] sadd(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? S64_MIN : S64_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // Saturating negate.
    function automatic logic signed [DATA_W-1:0] sneg(input logic signed [DATA_W-1:0] a);
        return (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    // Magnitude as an unsigned value.
    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] a);
        return a[DATA_W-1] ? (~a + 64'd1) : a;
    endfunction

endpackage

// File: rtl/free_surface_stress_update_unit.sv
// Channel   Dir  tuser        tdata (lowest bit first)
// s_axis    in   op[1:0]      tap_index, pml_x_region, pml_z_region, val_a..val_f
// m_axis    out  -            sxx_new, szz_new, psi_x_new, psi_z_new, divide_fault
// cfg       in   -            i_cfg_we, i_cfg_idx, i_cfg_wdata (one register per write)
//
// One item is worked at a time by a sequencer around one 64x64 multiplier,
// built from 32x32 partial products, and a radix-2 divider. A tap takes three
// products. Coefficient loads are taken in the idle state.
// A two-entry queue decouples input transfers from the sequencer, and the
// output register lets the next item start while a result waits.
// Reset is synchronous and active low; it clears the sums and CPML coefficients.
module free_surface_stress_update_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tap_index[2:0], pml_x_region[3], pml_z_region[4], val_a[68:5], val_b[132:69],
    // val_c[196:133], val_d[260:197], val_e[324:261], val_f[388:325]
    input  logic [fsu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op[1:0]
    input  logic [fsu_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sxx_new[63:0], szz_new[127:64], psi_x_new[191:128], psi_z_new[255:192],
    // divide_fault[256]
    output logic [fsu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [fsu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fsu_pkg::REG_W-1:0]           i_cfg_wdata
);
    import fsu_pkg::*;

    logic [HO_W-1:0]  r_half_order;
    logic             r_coeff_set;
    logic             r_pml_enable;
    logic [REG_W-1:0] r_time_step;
    logic [REG_W-1:0] r_inv_dx;
    logic [REG_W-1:0] r_inv_dy;
    logic [REG_W-1:0] r_inv_dz;

    t_cfg    cfg;
    logic    push;
    t_entry  push_entry;
    logic    q_full;
    logic    q_valid;
    t_entry  q_entry;
    logic    q_pop;
    t_result result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_order <= HO_W'(1);
            r_coeff_set  <= 1'b0;
            r_pml_enable <= 1'b0;
            r_time_step  <= '0;
            r_inv_dx     <= '0;
            r_inv_dy     <= '0;
            r_inv_dz     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_HALF_ORDER: r_half_order <= i_cfg_wdata[HO_W-1:0];
                REG_COEFF_SET:  r_coeff_set  <= i_cfg_wdata[0];
                REG_PML_ENABLE: r_pml_enable <= i_cfg_wdata[0];
                REG_TIME_STEP:  r_time_step  <= i_cfg_wdata;
                REG_INV_DX:     r_inv_dx     <= i_cfg_wdata;
                REG_INV_DY:     r_inv_dy     <= i_cfg_wdata;
                REG_INV_DZ:     r_inv_dz     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the half order into the supported range.
    always_comb begin
        cfg.half_order_eff = r_half_order;
        if (r_half_order == '0) begin
            cfg.half_order_eff = HO_W'(1);
        end else if (r_half_order > HO_W'(MAX_HALF_ORDER)) begin
            cfg.half_order_eff = HO_W'(MAX_HALF_ORDER);
        end
        cfg.coeff_set  = r_coeff_set;
        cfg.pml_enable = r_pml_enable;
        cfg.time_step  = r_time_step;
        cfg.inv_dx     = r_inv_dx;
        cfg.inv_dy     = r_inv_dy;
        cfg.inv_dz     = r_inv_dz;
    end

    fsu_front u_front (
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_data  (s_axis_tdata),
        .i_s_user  (s_axis_tuser),
        .i_cfg     (cfg),
        .o_push    (push),
        .o_entry   (push_entry),
        .i_full    (q_full)
    );

    fsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (q_pop)
    );

    fsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (q_valid),
        .i_entry   (q_entry),
        .o_pop     (q_pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

// File: rtl/fsu_queue.sv
module fsu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fsu_pkg::t_entry  i_entry,
    output logic             o_full,
    output logic             o_valid,
    output fsu_pkg::t_entry  o_entry,
    input  logic             i_pop
);
    import fsu_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// File: rtl/fsu_front.sv
module fsu_front (
    input  logic                               i_s_valid,
    output logic                               o_s_ready,
    input  logic [fsu_pkg::IN_TDATA_W-1:0]     i_s_data,
    input  logic [fsu_pkg::OP_W-1:0]           i_s_user,
    input  fsu_pkg::t_cfg                      i_cfg,
    output logic                               o_push,
    output fsu_pkg::t_entry                    o_entry,
    input  logic                               i_full
);
    import fsu_pkg::*;

    t_op             op;
    logic [HO_W-1:0] tap;
    logic            tap_ok;
    logic            keep;
    logic [HO_W-1:0] ho_i;
    logic [HO_W-1:0] tap_i;

    // Classify the item and look up its stencil coefficient.
    always_comb begin
        op     = t_op'(i_s_user);
        tap    = i_s_data[2:0];
        tap_ok = (tap != '0) && (tap <= i_cfg.half_order_eff);
        keep   = (op != OP_TAP) || tap_ok;
        ho_i   = i_cfg.half_order_eff - 1'b1;
        tap_i  = tap_ok ? (tap - 1'b1) : '0;

        o_entry.kind = op;
        o_entry.coef = CF_TAB[i_cfg.coeff_set][ho_i][tap_i];
        o_entry.xr   = i_s_data[3];
        o_entry.zr   = i_s_data[4];
        o_entry.va   = i_s_data[68:5];
        o_entry.vb   = i_s_data[132:69];
        o_entry.vc   = i_s_data[196:133];
        o_entry.vd   = i_s_data[260:197];
        o_entry.ve   = i_s_data[324:261];
        o_entry.vf   = i_s_data[388:325];
    end

    // Taps outside the stencil are taken and dropped.
    assign o_s_ready = !i_full;
    assign o_push    = i_s_valid && !i_full && keep;

endmodule

// File: rtl/fsu_mul.sv
module fsu_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fsu_pkg::DATA_W-1:0] i_a,
    input  logic signed [fsu_pkg::DATA_W-1:0] i_b,
    input  logic                              i_cf,
    output logic                              o_done,
    output logic signed [fsu_pkg::DATA_W-1:0] o_p
);
    import fsu_pkg::*;

    localparam logic [2:0] STEP_NEG = 3'd4;
    localparam logic [2:0] STEP_FIN = 3'd5;
    localparam logic signed [PROD_W-1:0] RND_FRAC = 128'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] RND_CF   = 128'sd1 <<< (CF_BITS - 1);

    logic                     r_busy;
    logic [2:0]               r_step;
    logic [DATA_W-1:0]        r_ma;
    logic [DATA_W-1:0]        r_mb;
    logic                     r_neg;
    logic                     r_cf;
    logic [PROD_W-1:0]        r_acc;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_p;

    logic [31:0]              a_h;
    logic [31:0]              b_h;
    logic [DATA_W-1:0]        pp;
    logic [PROD_W-1:0]        pp_sh;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [PROD_W-1:0] sh;
    logic signed [DATA_W-1:0] sat;

    // One 32x32 partial product per step, then negate, round, shift and saturate.
    always_comb begin
        a_h   = r_step[1] ? r_ma[63:32] : r_ma[31:0];
        b_h   = r_step[0] ? r_mb[63:32] : r_mb[31:0];
        pp    = a_h * b_h;
        pp_sh = PROD_W'(pp);
        if (r_step[1] && r_step[0]) begin
            pp_sh = PROD_W'(pp) << 64;
        end else if (r_step[1] || r_step[0]) begin
            pp_sh = PROD_W'(pp) << 32;
        end
        rnd_sum = $signed(r_acc) + (r_cf ? RND_CF : RND_FRAC);
        sh      = r_cf ? (rnd_sum >>> CF_BITS) : (rnd_sum >>> FRAC_BITS);
        if ((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1])) begin
            sat = sh[DATA_W-1:0];
        end else begin
            sat = sh[PROD_W-1] ? S64_MIN : S64_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == STEP_FIN);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_FIN) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operand and accumulator datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= mag(i_a);
            r_mb  <= mag(i_b);
            r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_cf  <= i_cf;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step < STEP_NEG) begin
                r_acc <= r_acc + pp_sh;
            end else if (r_step == STEP_NEG) begin
                r_acc <= r_neg ? (~r_acc + 1'b1) : r_acc;
            end else begin
                r_p <= sat;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// File: rtl/fsu_div.sv
module fsu_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fsu_pkg::DATA_W-1:0] i_n,
    input  logic signed [fsu_pkg::DATA_W-1:0] i_d,
    output logic                              o_done,
    output logic signed [fsu_pkg::DATA_W-1:0] o_q
);
    import fsu_pkg::*;

    localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

    logic                     r_run;
    logic                     r_fin;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic [DIV_STEPS-1:0]     r_nq;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_md;
    logic                     r_neg;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_q;

    logic [DATA_W:0]          trial;
    logic                     ge;
    logic [DATA_W-1:0]        q_lo;
    logic [DIV_STEPS-DATA_W-1:0] q_hi;
    logic signed [DATA_W-1:0] q_sat;

    // One quotient bit per cycle, shifted into the dividend register.
    always_comb begin
        trial = {r_rem, r_nq[DIV_STEPS-1]};
        ge    = (trial >= {1'b0, r_md});
        q_lo  = r_nq[DATA_W-1:0];
        q_hi  = r_nq[DIV_STEPS-1:DATA_W];
        if (r_neg) begin
            q_sat = ((|q_hi) || (q_lo > NEG_LIMIT)) ? S64_MIN : $signed(~q_lo + 1'b1);
        end else begin
            q_sat = ((|q_hi) || q_lo[DATA_W-1]) ? S64_MAX : $signed(q_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && !r_run && r_fin;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin <= 1'b0;
            end
        end
    end

    // Remainder and quotient datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= {mag(i_n), {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_md  <= mag(i_d);
            r_neg <= i_n[DATA_W-1] ^ i_d[DATA_W-1];
        end else if (r_run) begin
            r_rem <= ge ? DATA_W'(trial - {1'b0, r_md}) : trial[DATA_W-1:0];
            r_nq  <= {r_nq[DIV_STEPS-2:0], ge};
        end else if (r_fin) begin
            r_q <= q_sat;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// File: rtl/fsu_back.sv
module fsu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsu_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  fsu_pkg::t_entry   i_entry,
    output logic              o_pop,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output fsu_pkg::t_result  o_result
);
    import fsu_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    logic                     r_issued;
    t_entry                   r_item;
    logic signed [DATA_W-1:0] r_sum_x, r_sum_y, r_sum_z;
    logic signed [DATA_W-1:0] r_bx, r_ax, r_kx, r_bz, r_az, r_kz;
    logic signed [DATA_W-1:0] r_vxx, r_vyy, r_vzz, r_psx, r_psz;
    logic signed [DATA_W-1:0] r_d, r_t1, r_t2, r_t3, r_m, r_h;
    logic                     r_fault;
    logic                     r_out_valid;
    t_result                  r_out;

    logic                     cpml_on;
    logic                     use_mul;
    logic                     use_div;
    logic                     mul_start;
    logic                     div_start;
    logic signed [DATA_W-1:0] mul_a, mul_b, div_n, div_d;
    logic                     mul_cf;
    logic                     mul_done, div_done;
    logic signed [DATA_W-1:0] mul_p, div_q;
    logic                     out_load;

    fsu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_cf    (mul_cf),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    fsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (div_n),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign cpml_on = i_cfg.pml_enable && (i_cfg.half_order_eff <= 3'd2);

    // Sequencer: next state and unit operands.
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        use_mul  = 1'b0;
        use_div  = 1'b0;
        mul_a    = r_item.va;
        mul_b    = DATA_W'(r_item.coef);
        mul_cf   = 1'b0;
        div_n    = r_vxx;
        div_d    = r_kx;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop = 1'b1;
                if (i_valid) begin
                    if (i_entry.kind == OP_TAP) begin
                        n_state = ST_TAP_X;
                    end else if (i_entry.kind == OP_POINT) begin
                        n_state = ST_VXX;
                    end
                end
            end
            ST_TAP_X: begin
                use_mul = 1'b1;
                mul_cf  = 1'b1;
                if (mul_done) n_state = ST_TAP_Y;
            end
            ST_TAP_Y: begin
                use_mul = 1'b1;
                mul_cf  = 1'b1;
                mul_a   = r_item.vb;
                if (mul_done) n_state = ST_TAP_Z;
            end
            ST_TAP_Z: begin
                use_mul = 1'b1;
                mul_cf  = 1'b1;
                mul_a   = r_item.vc;
                if (mul_done) n_state = ST_IDLE;
            end
            ST_VXX: begin
                use_mul = 1'b1;
                mul_a   = r_sum_x;
                mul_b   = {1'b0, i_cfg.inv_dx};
                if (mul_done) n_state = ST_VYY;
            end
            ST_VYY: begin
                use_mul = 1'b1;
                mul_a   = r_sum_y;
                mul_b   = {1'b0, i_cfg.inv_dy};
                if (mul_done) n_state = ST_VZZ;
            end
            ST_VZZ: begin
                use_mul = 1'b1;
                mul_a   = r_sum_z;
                mul_b   = {1'b0, i_cfg.inv_dz};
                if (mul_done) begin
                    if (cpml_on && r_item.xr) begin
                        n_state = ST_PX_B;
                    end else if (cpml_on && r_item.zr) begin
                        n_state = ST_PZ_B;
                    end else begin
                        n_state = ST_T1;
                    end
                end
            end
            ST_PX_B: begin
                use_mul = 1'b1;
                mul_a   = r_bx;
                mul_b   = r_psx;
                if (mul_done) n_state = ST_PX_A;
            end
            ST_PX_A: begin
                use_mul = 1'b1;
                mul_a   = r_ax;
                mul_b   = r_vxx;
                if (mul_done) begin
                    if (r_kx != '0) begin
                        n_state = ST_PX_DIV;
                    end else if (r_item.zr) begin
                        n_state = ST_PZ_B;
                    end else begin
                        n_state = ST_T1;
                    end
                end
            end
            ST_PX_DIV: begin
                use_div = 1'b1;
                if (div_done) n_state = r_item.zr ? ST_PZ_B : ST_T1;
            end
            ST_PZ_B: begin
                use_mul = 1'b1;
                mul_a   = r_bz;
                mul_b   = r_psz;
                if (mul_done) n_state = ST_PZ_A;
            end
            ST_PZ_A: begin
                use_mul = 1'b1;
                mul_a   = r_az;
                mul_b   = r_vzz;
                if (mul_done) n_state = (r_kz != '0) ? ST_PZ_DIV : ST_T1;
            end
            ST_PZ_DIV: begin
                use_div = 1'b1;
                div_n   = r_vzz;
                div_d   = r_kz;
                if (div_done) n_state = ST_T1;
            end
            ST_T1: begin
                use_mul = 1'b1;
                mul_a   = {1'b0, i_cfg.time_step};
                mul_b   = r_d;
                if (mul_done) n_state = ST_T2;
            end
            ST_T2: begin
                use_mul = 1'b1;
                mul_a   = r_t1;
                mul_b   = r_d;
                if (mul_done) n_state = ST_T3;
            end
            ST_T3: begin
                use_mul = 1'b1;
                mul_a   = r_t2;
                mul_b   = sadd(r_vxx, r_vzz);
                if (mul_done) n_state = ST_T4;
            end
            ST_T4: begin
                use_mul = 1'b1;
                mul_a   = r_t1;
                mul_b   = r_vyy;
                if (mul_done) begin
                    n_state = (r_fault || (r_item.vb == '0)) ? ST_OUT : ST_HDIV;
                end
            end
            ST_HDIV: begin
                use_div = 1'b1;
                div_n   = r_t3;
                div_d   = r_item.vb;
                if (div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        mul_start = use_mul && !r_issued;
        div_start = use_div && !r_issued;
    end

    // Control state, running sums and CPML coefficients.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_bx        <= '0;
            r_ax        <= '0;
            r_kx        <= '0;
            r_bz        <= '0;
            r_az        <= '0;
            r_kz        <= '0;
        end else begin
            r_state <= n_state;
            if (mul_start || div_start) begin
                r_issued <= 1'b1;
            end else if (mul_done || div_done) begin
                r_issued <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_sum_x     <= '0;
                r_sum_y     <= '0;
                r_sum_z     <= '0;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_IDLE && i_valid) begin
                if (i_entry.kind == OP_PMLX) begin
                    r_bx <= i_entry.va;
                    r_ax <= i_entry.vb;
                    r_kx <= i_entry.vc;
                end else if (i_entry.kind == OP_PMLZ) begin
                    r_bz <= i_entry.va;
                    r_az <= i_entry.vb;
                    r_kz <= i_entry.vc;
                end
            end
            if (mul_done) begin
                unique case (r_state)
                    ST_TAP_X: r_sum_x <= sadd(r_sum_x, mul_p);
                    ST_TAP_Y: r_sum_y <= sadd(r_sum_y, mul_p);
                    ST_TAP_Z: r_sum_z <= sadd(r_sum_z, mul_p);
                    default: ;
                endcase
            end
        end
    end

    // Point datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_item  <= i_entry;
            r_psx   <= i_entry.ve;
            r_psz   <= i_entry.vf;
            r_fault <= 1'b0;
            r_h     <= '0;
            r_d     <= sadd(i_entry.vb, sneg(sadd(i_entry.va, i_entry.va)));
        end
        if (mul_done) begin
            unique case (r_state)
                ST_VXX:  r_vxx <= mul_p;
                ST_VYY:  r_vyy <= mul_p;
                ST_VZZ:  r_vzz <= mul_p;
                ST_PX_B: r_m   <= mul_p;
                ST_PX_A: begin
                    r_psx <= sadd(r_m, mul_p);
                    if (r_kx == '0) r_fault <= 1'b1;
                end
                ST_PZ_B: r_m   <= mul_p;
                ST_PZ_A: begin
                    r_psz <= sadd(r_m, mul_p);
                    if (r_kz == '0) r_fault <= 1'b1;
                end
                ST_T1:   r_t1  <= mul_p;
                ST_T2:   r_t2  <= mul_p;
                ST_T3:   r_t3  <= mul_p;
                ST_T4: begin
                    r_m <= mul_p;
                    if (r_item.vb == '0) r_fault <= 1'b1;
                end
                default: ;
            endcase
        end
        if (div_done) begin
            unique case (r_state)
                ST_PX_DIV: r_vxx <= sadd(div_q, r_psx);
                ST_PZ_DIV: r_vzz <= sadd(div_q, r_psz);
                ST_HDIV:   r_h   <= sadd(sneg(div_q), sneg(r_m));
                default: ;
            endcase
        end
        if (out_load) begin
            r_out.sxx   <= sadd(r_item.vc, r_h);
            r_out.szz   <= sadd(r_item.vd, r_h);
            r_out.psx   <= r_psx;
            r_out.psz   <= r_psz;
            r_out.fault <= r_fault;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_result  = r_out;

endmodule

// File: tb/free_surface_stress_update_unit_tb.sv
`timescale 1ns / 100ps

module free_surface_stress_update_unit_tb;
    import fsu_pkg::*;

    localparam int  RUN_LIMIT  = 2_000_000;
    localparam int  DRAIN_WAIT = 400;
    localparam longint Q_ONE   = 64'sd1 << FRAC_BITS;
    localparam logic [REG_W-1:0] REG_ALL_ONES = '1;

    // Stencil weights as signed numerator over denominator, by set, half order and tap.
    localparam longint WT_NUM [2][6][6] = '{
        '{'{1, 0, 0, 0, 0, 0},
          '{9, -1, 0, 0, 0, 0},
          '{75, -25, 3, 0, 0, 0},
          '{1225, -245, 49, -5, 0, 0},
          '{19845, -735, 567, -405, 35, 0},
          '{160083, -12705, 22869, -5445, 847, -63}},
        '{'{1, 0, 0, 0, 0, 0},
          '{11382, -46414, 0, 0, 0, 0},
          '{11965, -78804, 81781, 0, 0, 0},
          '{12257, -99537, 18063, -26274, 0, 0},
          '{12415, -11231, 26191, -64682, 1191, 0},
          '{12508, -12034, 32131, -10142, 29857, -66667}}
    };
    localparam longint WT_DEN [2][6][6] = '{
        '{'{1, 1, 1, 1, 1, 1},
          '{8, 24, 1, 1, 1, 1},
          '{64, 384, 640, 1, 1, 1},
          '{1024, 3072, 5120, 7168, 1, 1},
          '{16384, 8192, 40960, 229376, 294912, 1},
          '{131072, 131072, 1310720, 1835008, 2359296, 2883584}},
        '{'{1, 1, 1, 1, 1, 1},
          '{10000, 1000000, 1, 1, 1, 1},
          '{10000, 1000000, 10000000, 1, 1, 1},
          '{10000, 1000000, 1000000, 10000000, 1, 1},
          '{10000, 100000, 1000000, 10000000, 1000000, 1},
          '{10000, 100000, 1000000, 1000000, 10000000, 100000000}}
    };

    typedef logic signed [DATA_W-1:0] s64_t;

    typedef struct packed {
        t_op        op;
        logic [2:0] tap;
        logic       xr;
        logic       zr;
        s64_t       va, vb, vc, vd, ve, vf;
    } stim_t;

    typedef struct packed {
        s64_t sxx, szz, psx, psz;
        logic fault;
    } stress_t;

    // Fixed-point helpers shared by the predictor.
    function automatic s64_t sat_add(s64_t a, s64_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? S64_MIN : S64_MAX;
        return s[DATA_W-1:0];
    endfunction

    function automatic s64_t sat_neg(s64_t a);
        return (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    function automatic s64_t fx_mul(s64_t a, s64_t b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = pa * pb;
        p = (p + (128'sd1 <<< (sh - 1))) >>> sh;
        if (p > 128'(S64_MAX)) return S64_MAX;
        if (p < -(128'sd1 <<< 63)) return S64_MIN;
        return p[63:0];
    endfunction

    function automatic s64_t fx_div(s64_t n, s64_t d);
        logic [127:0] num, den, q;
        num = (n < 0) ? -n : n;
        den = (d < 0) ? -d : d;
        num[127:64] = 0;
        den[127:64] = 0;
        num = num << FRAC_BITS;
        q = num / den;
        if ((n < 0) != (d < 0)) begin
            if (q > (128'd1 << 63)) return S64_MIN;
            return -q[63:0];
        end
        if (q > 128'(S64_MAX)) return S64_MAX;
        return q[63:0];
    endfunction

    function automatic longint stencil_weight(int cset, int ho, int tap);
        longint n, d, r;
        n = WT_NUM[cset][ho-1][tap-1];
        d = WT_DEN[cset][ho-1][tap-1];
        r = ((n < 0 ? -n : n) * 64'sd2147483648 + d) / (2 * d);
        return (n < 0) ? -r : r;
    endfunction

    // Scoreboard: predicts each point result from accepted transfers and checks outputs.
    class stress_scoreboard;
        logic [2:0] half_order;
        bit         coeff_set, pml_enable;
        s64_t       time_step, inv_dx, inv_dy, inv_dz;
        s64_t       sum_x, sum_y, sum_z;
        s64_t       pml_x [3];
        s64_t       pml_z [3];
        stress_t    pending_q [$];
        int         errors;

        function new();
            half_order = 1;
            coeff_set  = 0;
            pml_enable = 0;
            time_step  = 0;
            inv_dx     = 0;
            inv_dy     = 0;
            inv_dz     = 0;
            sum_x      = 0;
            sum_y      = 0;
            sum_z      = 0;
            pml_x      = '{0, 0, 0};
            pml_z      = '{0, 0, 0};
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [REG_W-1:0] val);
            case (idx)
                REG_HALF_ORDER: half_order = val[2:0];
                REG_COEFF_SET:  coeff_set  = val[0];
                REG_PML_ENABLE: pml_enable = val[0];
                REG_TIME_STEP:  time_step  = {1'b0, val};
                REG_INV_DX:     inv_dx     = {1'b0, val};
                REG_INV_DY:     inv_dy     = {1'b0, val};
                REG_INV_DZ:     inv_dz     = {1'b0, val};
                default: ;
            endcase
        endfunction

        function int eff_half();
            if (half_order < 1) return 1;
            if (half_order > MAX_HALF_ORDER) return MAX_HALF_ORDER;
            return half_order;
        endfunction

        // CPML memory update; returns the corrected derivative.
        function s64_t cpml_fix(s64_t v, s64_t c [3], inout s64_t psi, inout bit fault);
            s64_t p;
            p = sat_add(fx_mul(c[0], psi, FRAC_BITS), fx_mul(c[1], v, FRAC_BITS));
            psi = p;
            if (c[2] == 0) begin
                fault = 1;
                return v;
            end
            return sat_add(fx_div(v, c[2]), p);
        endfunction

        function void note_transfer(stim_t it);
            int      ho;
            longint  w;
            s64_t    vxx, vyy, vzz, d, t1, t2, t3, h;
            stress_t r;
            bit      fault;
            ho = eff_half();
            case (it.op)
                OP_TAP: begin
                    if (it.tap >= 1 && it.tap <= ho) begin
                        w = stencil_weight(coeff_set, ho, it.tap);
                        sum_x = sat_add(sum_x, fx_mul(it.va, w, CF_BITS));
                        sum_y = sat_add(sum_y, fx_mul(it.vb, w, CF_BITS));
                        sum_z = sat_add(sum_z, fx_mul(it.vc, w, CF_BITS));
                    end
                end
                OP_PMLX: pml_x = '{it.va, it.vb, it.vc};
                OP_PMLZ: pml_z = '{it.va, it.vb, it.vc};
                default: begin
                    vxx = fx_mul(sum_x, inv_dx, FRAC_BITS);
                    vyy = fx_mul(sum_y, inv_dy, FRAC_BITS);
                    vzz = fx_mul(sum_z, inv_dz, FRAC_BITS);
                    r.psx = it.ve;
                    r.psz = it.vf;
                    fault = 0;
                    h = 0;
                    if (pml_enable && ho <= 2) begin
                        if (it.xr) vxx = cpml_fix(vxx, pml_x, r.psx, fault);
                        if (it.zr) vzz = cpml_fix(vzz, pml_z, r.psz, fault);
                    end
                    d  = sat_add(it.vb, sat_neg(sat_add(it.va, it.va)));
                    t1 = fx_mul(time_step, d, FRAC_BITS);
                    t2 = fx_mul(t1, d, FRAC_BITS);
                    t3 = fx_mul(t2, sat_add(vxx, vzz), FRAC_BITS);
                    if (it.vb == 0) fault = 1;
                    if (!fault)
                        h = sat_add(sat_neg(fx_div(t3, it.vb)),
                                    sat_neg(fx_mul(t1, vyy, FRAC_BITS)));
                    r.sxx   = sat_add(it.vc, h);
                    r.szz   = sat_add(it.vd, h);
                    r.fault = fault;
                    pending_q.push_back(r);
                    sum_x = 0;
                    sum_y = 0;
                    sum_z = 0;
                end
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        endtask

        task check_result(stress_t got);
            stress_t want;
            if (pending_q.size() == 0) begin
                report("unexpected result", got.sxx, 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.sxx !== want.sxx) report("sxx_new", got.sxx, want.sxx);
            if (got.szz !== want.szz) report("szz_new", got.szz, want.szz);
            if (got.psx !== want.psx) report("psi_x_new", got.psx, want.psx);
            if (got.psz !== want.psz) report("psi_z_new", got.psz, want.psz);
            if (got.fault !== want.fault) report("divide_fault", got.fault, want.fault);
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [REG_W-1:0]       i_cfg_wdata;

    stress_scoreboard sb;
    bit               steady;
    int               cycles;

    free_surface_stress_update_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Input transfers feed the predictor.
    always @(posedge i_clk) begin
        stim_t it;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.op  = t_op'(s_axis_tuser);
            it.tap = s_axis_tdata[2:0];
            it.xr  = s_axis_tdata[3];
            it.zr  = s_axis_tdata[4];
            it.va  = s_axis_tdata[68:5];
            it.vb  = s_axis_tdata[132:69];
            it.vc  = s_axis_tdata[196:133];
            it.vd  = s_axis_tdata[260:197];
            it.ve  = s_axis_tdata[324:261];
            it.vf  = s_axis_tdata[388:325];
            sb.note_transfer(it);
        end
    end

    // Output transfers are checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tdata[63:0], m_axis_tdata[127:64],
                             m_axis_tdata[191:128], m_axis_tdata[255:192],
                             m_axis_tdata[256]});
    end

    // Receiver stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 24);
    end

    task automatic write_reg(t_cfg_reg idx, logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Waits until every predicted result has arrived and the block has gone quiet.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_all(logic [2:0] ho, bit cset, bit pen, logic [REG_W-1:0] ts,
                           logic [REG_W-1:0] dx, logic [REG_W-1:0] dy,
                           logic [REG_W-1:0] dz);
        write_reg(REG_HALF_ORDER, REG_W'(ho));
        write_reg(REG_COEFF_SET, REG_W'(cset));
        write_reg(REG_PML_ENABLE, REG_W'(pen));
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_INV_DX, dx);
        write_reg(REG_INV_DY, dy);
        write_reg(REG_INV_DZ, dz);
    endtask

    // Drives one item; the sender idles first at random.
    task automatic send(stim_t it);
        int gap;
        gap = steady ? 0 : (($urandom_range(0, 99) < 24) ? $urandom_range(1, 4) : 0);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.op;
        s_axis_tdata  = {3'b000, it.vf, it.ve, it.vd, it.vc, it.vb, it.va,
                         it.zr, it.xr, it.tap};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic s64_t rand_val();
        case ($urandom_range(0, 11))
            0: return S64_MIN;
            1: return S64_MAX;
            2: return 0;
            3, 4: return {$urandom, $urandom};
            default: return longint'($signed($urandom)) <<< $urandom_range(0, 14);
        endcase
    endfunction

    function automatic stim_t make_item(t_op op, logic [2:0] tap);
        stim_t it;
        it.op  = op;
        it.tap = tap;
        it.xr  = 1'($urandom_range(0, 1));
        it.zr  = 1'($urandom_range(0, 1));
        it.va  = rand_val();
        it.vb  = rand_val();
        it.vc  = rand_val();
        it.vd  = rand_val();
        it.ve  = rand_val();
        it.vf  = rand_val();
        // Keep K and the P-wave modulus mostly nonzero so that h is formed.
        if (op != OP_TAP && op != OP_POINT && it.vc == 0 && $urandom_range(0, 1))
            it.vc = Q_ONE;
        if (op == OP_POINT && it.vb == 0 && $urandom_range(0, 1)) it.vb = 3 * Q_ONE;
        return it;
    endfunction

    function automatic stim_t make_point(s64_t mu, s64_t lam2mu, bit xr, bit zr);
        stim_t it;
        it    = make_item(OP_POINT, 3'd0);
        it.va = mu;
        it.vb = lam2mu;
        it.xr = xr;
        it.zr = zr;
        return it;
    endfunction

    // Well-formed update: optional PML loads, every tap in order, then the point.
    task automatic send_update(int ho);
        stim_t it;
        if (sb.pml_enable && $urandom_range(0, 1)) send(make_item(OP_PMLX, 3'd0));
        if (sb.pml_enable && $urandom_range(0, 1)) send(make_item(OP_PMLZ, 3'd0));
        for (int t = 1; t <= ho; t++) send(make_item(OP_TAP, 3'(t)));
        send(make_item(OP_POINT, 3'd0));
    endtask

    // Main stimulus.
    initial begin
        int        sent;
        int        ho;
        stim_t     it;
        sb = new();
        steady        = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TAP;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_HALF_ORDER;
        i_cfg_wdata   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset configuration, two points with zero sums, the first with zero modulus.
        send(make_point(Q_ONE, 0, 1, 1));
        send(make_point(Q_ONE, 4 * Q_ONE, 0, 0));
        drain();

        // Directed: second order with CPML on, extremes, ignored taps, faults.
        set_all(3'd2, 1'b0, 1'b1, REG_W'(Q_ONE >>> 4), REG_W'(Q_ONE), REG_W'(Q_ONE),
                REG_W'(Q_ONE));
        it = make_item(OP_PMLX, 3'd0);
        it.va = Q_ONE >>> 1; it.vb = Q_ONE >>> 2; it.vc = Q_ONE;
        send(it);
        it.op = OP_PMLZ; it.vc = 0;
        send(it);
        it = make_item(OP_TAP, 3'd1);
        it.va = Q_ONE; it.vb = -Q_ONE; it.vc = 2 * Q_ONE;
        send(it);
        it.tap = 3'd2;
        send(it);
        it.tap = 3'd0;
        send(it);
        it.tap = 3'd7;
        send(it);
        send(make_point(Q_ONE, 4 * Q_ONE, 1, 0));
        send(make_point(Q_ONE, 4 * Q_ONE, 0, 1));
        it = make_item(OP_TAP, 3'd1);
        it.va = S64_MAX; it.vb = S64_MIN; it.vc = S64_MAX;
        send(it);
        send(it);
        it.tap = 3'd2; it.va = S64_MIN; it.vb = S64_MAX; it.vc = S64_MIN;
        send(it);
        send(make_point(S64_MIN, S64_MAX, 1, 1));
        send(make_point(S64_MAX, S64_MIN, 0, 0));
        send(make_point(-1, 1, 0, 0));
        it = make_item(OP_PMLZ, 3'd0);
        it.va = S64_MIN; it.vb = S64_MAX; it.vc = -1;
        send(it);
        send(make_point(Q_ONE, 0, 1, 1));
        drain();

        // Random phases, each with its own configuration.
        sent = 0;
        for (int ph = 0; sent < 750; ph++) begin
            case (ph)
                0: set_all(3'd6, 1'b1, 1'b1, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES,
                           REG_ALL_ONES);
                1: set_all(3'd0, 1'b0, 1'b0, '0, '0, '0, '0);
                2: set_all(3'd7, 1'b1, 1'b1, REG_W'(Q_ONE), REG_W'(Q_ONE), REG_W'(Q_ONE),
                           REG_W'(Q_ONE));
                default: set_all(($urandom_range(0, 2) != 0) ? 3'($urandom_range(1, 2))
                                                             : 3'($urandom_range(0, 7)),
                                 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                                 REG_W'($urandom) << $urandom_range(0, 8),
                                 REG_W'($urandom) << $urandom_range(0, 4),
                                 REG_W'($urandom) << $urandom_range(0, 4),
                                 ($urandom_range(0, 9) == 0) ? REG_W'({$urandom, $urandom})
                                                            : REG_W'($urandom));
            endcase
            steady = (ph == 3);
            ho = sb.eff_half();
            for (int k = 0; k < 60 && sent < 750; k++) begin
                if ($urandom_range(0, 99) < 80) begin
                    send_update(ho);
                    sent += ho + 1;
                end else begin
                    send(make_item(t_op'($urandom_range(0, 3)), 3'($urandom_range(0, 7))));
                    sent++;
                end
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/fsu_pkg.sv
rtl/fsu_queue.sv
rtl/fsu_front.sv
rtl/fsu_mul.sv
rtl/fsu_div.sv
rtl/fsu_back.sv
rtl/free_surface_stress_update_unit.sv
tb/free_surface_stress_update_unit_tb.sv
